// ----- sv/lbd_pkg.sv -----
`timescale 1ns / 1ps

package lbd_pkg;

	// Field and register widths
	localparam int ALPHA_W    = 16;
	localparam int RATIO_W    = 7;
	localparam int AVG_W      = 32;
	localparam int CNT_W      = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Filter datapath: Q16.16 value times a 17-bit coefficient (sign bit added)
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = ALPHA_W + 2;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int FRAC_W  = 16;

	// Window sum holds up to 2^RATIO_W - 1 Q16.16 values
	localparam int SUM_W = AVG_W + RATIO_W;

	// Register reset values
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'h8000;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 7'd1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_P,
		ST_ACC,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} lbd_state_t;

	// Clamp a wide signed value to the Q16.16 range
	function automatic logic signed [AVG_W-1:0] sat_q16(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(signed'({1'b0, {(AVG_W-1){1'b1}}}));
		lo = PROD_W'(signed'({1'b1, {(AVG_W-1){1'b0}}}));
		if (v > hi) begin
			sat_q16 = {1'b0, {(AVG_W-1){1'b1}}};
		end else if (v < lo) begin
			sat_q16 = {1'b1, {(AVG_W-1){1'b0}}};
		end else begin
			sat_q16 = v[AVG_W-1:0];
		end
	endfunction

endpackage

// ----- sv/lbd_ifs.sv -----
`timescale 1ns / 1ps

// Sample channel
interface lbd_smp_if #(parameter int SAMPLE_BITS = 16) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last;

	modport source (output valid, sample, last, input ready);
	modport sink (input valid, sample, last, output ready);
endinterface

// Result channel
interface lbd_res_if import lbd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [AVG_W-1:0] avg_sample;
	logic [CNT_W-1:0]        window_count;
	logic                    end_of_signal;

	modport source (output valid, avg_sample, window_count, end_of_signal, input ready);
	modport sink (input valid, avg_sample, window_count, end_of_signal, output ready);
endinterface

// Configuration write channel
interface lbd_cfg_if import lbd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, idx, wdata, input ready);
	modport sink (input valid, idx, wdata, output ready);
endinterface

// ----- sv/lbd_div.sv -----
`timescale 1ns / 1ps

// Floored signed division of the window sum by the fill count,
// restoring, one quotient bit per cycle, then a sign-fix step.
module lbd_div import lbd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	output logic                    done,
	output logic signed [AVG_W-1:0] quotient
);

	localparam int STEP_W = $clog2(SUM_W);

	logic                    run_q;
	logic                    fix_q;
	logic                    done_q;
	logic [STEP_W-1:0]       step_q;
	logic                    neg_q;
	logic [SUM_W-1:0]        mag_q;
	logic [CNT_W-1:0]        rem_q;
	logic [CNT_W-1:0]        dvs_q;
	logic signed [AVG_W-1:0] quo_q;

	logic [CNT_W:0] trial;
	logic           fits;
	logic [SUM_W-1:0] signed_q;

	assign trial = {rem_q, mag_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Negative: floor of -(mag / d) is ~mag + 1 when exact, ~mag otherwise
	assign signed_q = neg_q ? (~mag_q + SUM_W'(rem_q == '0)) : mag_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					run_q <= 1'b0;
					fix_q <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Shift-subtract datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			mag_q <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			mag_q <= {mag_q[SUM_W-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
		end else if (fix_q) begin
			quo_q <= signed_q[AVG_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/lowpass_box_decimator.sv -----
`timescale 1ns / 1ps

// One-pole low-pass filter followed by boxcar decimation.
// Channels: samples (sink) takes a signed sample and a last flag; results
// (source) gives the floored Q16.16 window mean, the number of samples in the
// window and an end-of-signal flag; cfg takes register writes (index 0 alpha,
// index 1 decimation ratio) and is always ready; write it only while idle.
// Each accepted sample runs through one shared 32x18 multiplier in two passes
// (alpha*x, then (1-alpha)*y_prev), then an accumulate step in ACC.
// A sample that does not close a window passes MUL_X, MUL_P and ACC first.
// A sample that closes a window (ratio reached or last) also runs the
// bit-serial divider, one quotient bit per cycle over 39 bits; its result is
// registered on leaving EMIT, and the next sample is taken only back in IDLE.
// The result register holds while the receiver stalls; the block
// takes further samples meanwhile and waits only when a new result is due.
// Reset clears the filter state, the window and the result valid, and sets
// alpha to one half and the ratio to one. After a last sample the filter and
// the window restart from zero.
module lowpass_box_decimator import lbd_pkg::*; #(
	parameter int MAX_RATIO   = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	lbd_smp_if.sink   samples,
	lbd_res_if.source results,
	lbd_cfg_if.sink   cfg
);

	lbd_state_t state_q;
	lbd_state_t state_d;

	// Configuration
	logic [ALPHA_W-1:0] alpha_q;
	logic [RATIO_W-1:0] ratio_q;

	// Item and filter state
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          last_q;
	logic signed [AVG_W-1:0]       prev_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]              fill_q;
	logic signed [PROD_W-1:0]      acc_q;
	logic signed [PROD_W-1:0]      prod_q;

	// Result register
	logic                    res_valid_q;
	logic signed [AVG_W-1:0] res_avg_q;
	logic [CNT_W-1:0]        res_count_q;
	logic                    res_eos_q;

	logic                     in_ready;
	logic                     div_start;
	logic                     div_done;
	logic signed [AVG_W-1:0]  div_quo;
	logic                     out_free;
	logic [RATIO_W-1:0]       ratio_eff;
	logic [CNT_W-1:0]         fill_inc;
	logic                     window_hit;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic [ALPHA_W:0]          one_minus;
	logic signed [AVG_W-1:0]   y_val;

	assign out_free = !res_valid_q || results.ready;

	// Ratio clamp: zero acts as one, above MAX_RATIO saturates
	always_comb begin
		if (ratio_q == '0) begin
			ratio_eff = RATIO_W'(1);
		end else if (int'(ratio_q) > MAX_RATIO) begin
			ratio_eff = RATIO_W'(MAX_RATIO);
		end else begin
			ratio_eff = ratio_q;
		end
	end

	assign fill_inc   = fill_q + 1'b1;
	assign window_hit = (fill_inc >= ratio_eff) || last_q;

	// Shared multiplier: alpha*x in MUL_X, (1-alpha)*y_prev in MUL_P
	assign one_minus = (ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, alpha_q};
	always_comb begin
		if (state_q == ST_MUL_X) begin
			mul_a = MUL_A_W'(x_q);
			mul_b = signed'({2'b00, alpha_q});
		end else begin
			mul_a = prev_q;
			mul_b = signed'({1'b0, one_minus});
		end
	end
	assign mul_p = mul_a * mul_b;

	// Filter output: arithmetic shift gives the floor of the Q16 product
	assign y_val = sat_q16(acc_q + (prod_q >>> FRAC_W));

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (samples.valid) begin
					state_d = ST_MUL_X;
				end
			end
			ST_MUL_X: begin
				state_d = ST_MUL_P;
			end
			ST_MUL_P: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = window_hit ? ST_DIV_GO : ST_IDLE;
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			ratio_q <= RATIO_RESET;
		end else if (cfg.valid) begin
			case (cfg.idx)
				CFG_ALPHA: alpha_q <= cfg.wdata[ALPHA_W-1:0];
				CFG_RATIO: ratio_q <= cfg.wdata[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	// Filter and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			sum_q  <= '0;
			fill_q <= '0;
		end else if (state_q == ST_ACC) begin
			prev_q <= y_val;
			sum_q  <= sum_q + SUM_W'(y_val);
			fill_q <= fill_inc;
		end else if (state_q == ST_EMIT && out_free) begin
			sum_q  <= '0;
			fill_q <= '0;
			if (last_q) begin
				prev_q <= '0;
			end
		end
	end

	// Input capture and product registers
	always_ff @(posedge clk) begin
		if (in_ready && samples.valid) begin
			x_q    <= samples.sample;
			last_q <= samples.last;
		end
		if (state_q == ST_MUL_X) begin
			acc_q <= mul_p;
		end
		if (state_q == ST_MUL_P) begin
			prod_q <= mul_p;
		end
	end

	lbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (fill_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			res_avg_q   <= div_quo;
			res_count_q <= fill_q;
			res_eos_q   <= last_q;
		end
	end

	assign samples.ready         = in_ready;
	assign cfg.ready             = 1'b1;
	assign results.valid         = res_valid_q;
	assign results.avg_sample    = res_avg_q;
	assign results.window_count  = res_count_q;
	assign results.end_of_signal = res_eos_q;

endmodule

// ----- sv/lbd_chk.sv -----
`timescale 1ns / 1ps

module lbd_chk import lbd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_valid,
	input logic             s_ready,
	input logic             r_valid,
	input logic             r_ready,
	input logic [CNT_W-1:0] r_count
);

	// A stalled result stays offered and its count unchanged
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_count))
		else $error("result dropped or changed under stall");

	// After a sample is taken the filter stays busy, not ready, through its multiply and accumulate steps
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready ##1 !s_ready ##1 !s_ready)
		else $error("sample taken while filter busy");

	// A result always averages at least one sample
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> r_count != '0)
		else $error("result with empty window");

endmodule

bind lowpass_box_decimator lbd_chk u_lbd_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (samples.valid),
	.s_ready (samples.ready),
	.r_valid (results.valid),
	.r_ready (results.ready),
	.r_count (results.window_count)
);
